// ===== hdl/bmm_pkg.sv =====
package bmm_pkg;

    localparam int unsigned MAX_DIM_DEF = 16;

    localparam int unsigned MODE_W  = 2;
    localparam int unsigned COORD_W = 4;
    localparam int unsigned ELEM_W  = 16;
    localparam int unsigned MUL_W   = 2 * ELEM_W;
    localparam int unsigned PROD_W  = 36;
    localparam int unsigned SIZE_W  = 5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = SIZE_W;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    typedef enum logic [MODE_W-1:0] {
        MODE_WR_A = 2'd0,
        MODE_WR_B = 2'd1,
        MODE_RD   = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS  = 3'd0,
        CFG_INNER   = 3'd1,
        CFG_B_COLS  = 3'd2,
        CFG_A_TRANS = 3'd3,
        CFG_B_TRANS = 3'd4
    } cfg_idx_t;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic a_we;
        logic b_we;
        logic rd_en;
        logic acc_clr;
    } dp_ctrl_t;

endpackage

// ===== hdl/bmm_datapath.sv =====
module bmm_datapath #(
    parameter int unsigned MAX_DIM = bmm_pkg::MAX_DIM_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  bmm_pkg::dp_ctrl_t                        ctrl,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       waddr,
    input  logic [bmm_pkg::ELEM_W-1:0]               wdata,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       a_raddr,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]       b_raddr,
    output logic signed [bmm_pkg::PROD_W-1:0]        acc,
    output logic                                     busy
);
    import bmm_pkg::*;

    localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

    logic [ELEM_W-1:0]        a_mem [DEPTH];
    logic [ELEM_W-1:0]        b_mem [DEPTH];
    logic [ELEM_W-1:0]        a_q_reg;
    logic [ELEM_W-1:0]        b_q_reg;
    logic signed [MUL_W-1:0]  mul_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic                     rd_vld_reg;
    logic                     mul_vld_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.a_we)
        begin
            a_mem[waddr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            a_q_reg <= a_mem[a_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.b_we)
        begin
            b_mem[waddr] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            b_q_reg <= b_mem[b_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= ctrl.rd_en;
            mul_vld_reg <= rd_vld_reg;
        end
    end

    // q8.8 times q8.8 gives an exact q16.16 term
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            mul_reg <= signed'(a_q_reg) * signed'(b_q_reg);
        end
    end

    // sum wraps at the accumulator width
    always_ff @(posedge clk)
    begin
        if (ctrl.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_reg <= acc_reg + {{(PROD_W-MUL_W){mul_reg[MUL_W-1]}}, mul_reg};
        end
    end

    assign acc  = acc_reg;
    assign busy = rd_vld_reg | mul_vld_reg;

endmodule

// ===== hdl/blocked_matrix_multiply.sv =====
// Matrix product engine. A mode 0 or 1 beat writes one q8.8 element of A or B
// into its store at (row, col) without stalling the input; writes outside the stored
// shape are dropped. A mode 2 beat reads C(row, col) = sum over k of
// A'(row,k) * B'(k,col), with A' and B' the stores seen through their
// transpose flags, returned as an exact q20.16 sum. One multiply-accumulate
// unit takes one inner element per cycle behind a registered store read; an
// in-range read keeps the input stalled while it runs and drains, and its result
// beat appears at the edge that ends the stall; a read outside a_rows x b_cols
// returns 0 with out_of_range set, with the input stalled until then. Both
// stretch while an earlier result beat is still held by out_stall. Store
// contents are undefined until written and reads of unwritten entries give
// undefined sums. Configure only while no read is in flight.
module blocked_matrix_multiply #(
    parameter int unsigned MAX_DIM = bmm_pkg::MAX_DIM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bmm_pkg::MODE_W-1:0]         mode,
    input  logic [bmm_pkg::COORD_W-1:0]        row,
    input  logic [bmm_pkg::COORD_W-1:0]        col,
    input  logic signed [bmm_pkg::ELEM_W-1:0]  value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [bmm_pkg::PROD_W-1:0]  product,
    output logic                               out_of_range,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bmm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bmm_pkg::*;

    localparam int unsigned CW = $clog2(MAX_DIM + 1);
    localparam int unsigned AW = $clog2(MAX_DIM * MAX_DIM);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       k_reg, k_next;
    logic [COORD_W-1:0]  rd_row_reg, rd_row_next;
    logic [COORD_W-1:0]  rd_col_reg, rd_col_next;
    logic                oor_reg, oor_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [PROD_W-1:0] product_reg, product_next;
    logic                out_of_range_reg, out_of_range_next;

    logic [SIZE_W-1:0]   a_rows_reg, inner_reg, b_cols_reg;
    logic                a_trans_reg, b_trans_reg;

    logic [CW-1:0]       m, n, p;
    logic [CW-1:0]       a_row_lim, a_col_lim, b_row_lim, b_col_lim;
    logic                a_wr_ok, b_wr_ok, rd_oor;
    logic [AW-1:0]       waddr, a_raddr, b_raddr;
    dp_ctrl_t            ctrl;
    logic signed [PROD_W-1:0] acc;
    logic                busy;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg  <= SIZE_RESET;
            inner_reg   <= SIZE_RESET;
            b_cols_reg  <= SIZE_RESET;
            a_trans_reg <= 1'b0;
            b_trans_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_A_ROWS:  a_rows_reg  <= cfg_data;
                CFG_INNER:   inner_reg   <= cfg_data;
                CFG_B_COLS:  b_cols_reg  <= cfg_data;
                CFG_A_TRANS: a_trans_reg <= cfg_data[0];
                CFG_B_TRANS: b_trans_reg <= cfg_data[0];
                default:     ;
            endcase
        end
    end

    // sizes above the store dimension act as the store dimension
    always_comb
    begin
        m = (32'(a_rows_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(a_rows_reg);
        n = (32'(inner_reg)  > MAX_DIM) ? CW'(MAX_DIM) : CW'(inner_reg);
        p = (32'(b_cols_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(b_cols_reg);
    end

    always_comb
    begin
        a_row_lim = a_trans_reg ? n : m;
        a_col_lim = a_trans_reg ? m : n;
        b_row_lim = b_trans_reg ? p : n;
        b_col_lim = b_trans_reg ? n : p;
        a_wr_ok   = (32'(row) < 32'(a_row_lim)) && (32'(col) < 32'(a_col_lim));
        b_wr_ok   = (32'(row) < 32'(b_row_lim)) && (32'(col) < 32'(b_col_lim));
        rd_oor    = (32'(row) >= 32'(m)) || (32'(col) >= 32'(p));
        waddr     = AW'(32'(row) * MAX_DIM + 32'(col));
        a_raddr   = a_trans_reg ? AW'(32'(k_reg) * MAX_DIM + 32'(rd_row_reg))
                                : AW'(32'(rd_row_reg) * MAX_DIM + 32'(k_reg));
        b_raddr   = b_trans_reg ? AW'(32'(rd_col_reg) * MAX_DIM + 32'(k_reg))
                                : AW'(32'(k_reg) * MAX_DIM + 32'(rd_col_reg));
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        rd_row_next       = rd_row_reg;
        rd_col_next       = rd_col_reg;
        oor_next          = oor_reg;
        out_valid_next    = out_valid_reg && out_stall;
        product_next      = product_reg;
        out_of_range_next = out_of_range_reg;
        ctrl              = '0;
        in_stall          = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    case (mode)
                        MODE_WR_A:
                        begin
                            ctrl.a_we = a_wr_ok;
                        end
                        MODE_WR_B:
                        begin
                            ctrl.b_we = b_wr_ok;
                        end
                        MODE_RD:
                        begin
                            rd_row_next  = row;
                            rd_col_next  = col;
                            oor_next     = rd_oor;
                            k_next       = '0;
                            ctrl.acc_clr = 1'b1;
                            if (rd_oor || n == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN:
            begin
                ctrl.rd_en = 1'b1;
                k_next     = CW'(k_reg + 1'b1);
                if (CW'(k_reg + 1'b1) == n)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the last term to reach the accumulator
                if (!busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    product_next      = oor_reg ? '0 : acc;
                    out_of_range_next = oor_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            oor_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            oor_reg       <= oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg       <= rd_row_next;
        rd_col_reg       <= rd_col_next;
        product_reg      <= product_next;
        out_of_range_reg <= out_of_range_next;
    end

    assign out_valid    = out_valid_reg;
    assign product      = product_reg;
    assign out_of_range = out_of_range_reg;

    bmm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .waddr   (waddr),
        .wdata   (value),
        .a_raddr (a_raddr),
        .b_raddr (b_raddr),
        .acc     (acc),
        .busy    (busy)
    );

endmodule

// ===== hdl/bmm_checker.sv =====
module bmm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic [bmm_pkg::MODE_W-1:0]         mode,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [bmm_pkg::PROD_W-1:0]  product,
    input logic                               out_of_range
);
    import bmm_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product) && $stable(out_of_range))
        else $error("result beat changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> product == '0)
        else $error("out of range result carries nonzero product");

    // writes and unused modes finish in the cycle they are taken
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode != MODE_RD |=> !in_stall)
        else $error("input stalled after a write beat");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == MODE_RD |=> in_stall)
        else $error("input not stalled while a read is in flight");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode != MODE_RD && !out_valid |=> !out_valid)
        else $error("result beat appeared after a write beat");

endmodule

bind blocked_matrix_multiply bmm_checker u_bmm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .product      (product),
    .out_of_range (out_of_range)
);
